// ===== rtl/vab_pkg.sv =====
// shared constants, tables and types for the view angle to basis block
package vab_pkg;

   // default build options
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int CORDIC_MAX_STEPS  = 24;

   // angle units: 1/64 degree, full turn
   localparam int FULL_TURN = 23040;

   // configuration register indexes
   localparam logic [1:0] REG_DEAD_ZONE   = 2'd0;
   localparam logic [1:0] REG_TURN_GAIN   = 2'd1;
   localparam logic [1:0] REG_PITCH_LIMIT = 2'd2;

   // configuration reset values
   localparam logic [14:0] DEAD_ZONE_RST   = 15'd5243;
   localparam logic [14:0] TURN_GAIN_RST   = 15'd320;
   localparam logic [12:0] PITCH_LIMIT_RST = 13'd2880;

   // cordic datapath: x and y in q2.30, z a 32 bit binary angle, with headroom
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

   typedef logic signed [31:0] trig_type;

   typedef struct packed {
      trig_type sin_val;
      trig_type cos_val;
   } cordic_res_type;

   // arctangent of 2^-i as a 32 bit binary angle
   localparam logic [29:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81
   };

   // reciprocal of 45 scaled by 2^20, rounded up
   localparam logic [14:0] RECIP45 = 15'd23302;

   // low 23 bits of the binary angle for each residue of r mod 45
   localparam longint BAM_ONE = 64'd8388608;
   localparam logic [22:0] FRAC_TAB [45] = '{
      23'((0*BAM_ONE+22)/45),  23'((1*BAM_ONE+22)/45),  23'((2*BAM_ONE+22)/45),
      23'((3*BAM_ONE+22)/45),  23'((4*BAM_ONE+22)/45),  23'((5*BAM_ONE+22)/45),
      23'((6*BAM_ONE+22)/45),  23'((7*BAM_ONE+22)/45),  23'((8*BAM_ONE+22)/45),
      23'((9*BAM_ONE+22)/45),  23'((10*BAM_ONE+22)/45), 23'((11*BAM_ONE+22)/45),
      23'((12*BAM_ONE+22)/45), 23'((13*BAM_ONE+22)/45), 23'((14*BAM_ONE+22)/45),
      23'((15*BAM_ONE+22)/45), 23'((16*BAM_ONE+22)/45), 23'((17*BAM_ONE+22)/45),
      23'((18*BAM_ONE+22)/45), 23'((19*BAM_ONE+22)/45), 23'((20*BAM_ONE+22)/45),
      23'((21*BAM_ONE+22)/45), 23'((22*BAM_ONE+22)/45), 23'((23*BAM_ONE+22)/45),
      23'((24*BAM_ONE+22)/45), 23'((25*BAM_ONE+22)/45), 23'((26*BAM_ONE+22)/45),
      23'((27*BAM_ONE+22)/45), 23'((28*BAM_ONE+22)/45), 23'((29*BAM_ONE+22)/45),
      23'((30*BAM_ONE+22)/45), 23'((31*BAM_ONE+22)/45), 23'((32*BAM_ONE+22)/45),
      23'((33*BAM_ONE+22)/45), 23'((34*BAM_ONE+22)/45), 23'((35*BAM_ONE+22)/45),
      23'((36*BAM_ONE+22)/45), 23'((37*BAM_ONE+22)/45), 23'((38*BAM_ONE+22)/45),
      23'((39*BAM_ONE+22)/45), 23'((40*BAM_ONE+22)/45), 23'((41*BAM_ONE+22)/45),
      23'((42*BAM_ONE+22)/45), 23'((43*BAM_ONE+22)/45), 23'((44*BAM_ONE+22)/45)
   };

endpackage

// ===== rtl/view_angle_to_basis_top.sv =====
// view angle update and left, up, forward basis generation
//
//  channel | ports                    | direction | moves
//  req     | req_valid/req_stall      | in        | one stick tick (two axes)
//  rsp     | rsp_valid/rsp_stall      | out       | angles and nine basis terms
//  csr     | csr_write/index/data     | in        | one register write
//
// an item passes through two angle steps (yaw, then pitch, with a yaw wrap when the
// horizontal axis is active), two cordic passes and four products before the result load.
// req_stall is high from the transfer until the result is loaded into the
// output register; a held result only delays that load.
// reset is synchronous; it clears angles and control state and sets the configuration registers to their reset values.
module view_angle_to_basis_top #(
   parameter int CORDIC_STEPS  = vab_pkg::CORDIC_STEPS_DEF,
   parameter int OUT_FRAC_BITS = vab_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_horizontal_axis,
   input  logic signed [15:0] req_vertical_axis,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_yaw_now,
   output logic signed [13:0] rsp_pitch_now,
   output logic signed [15:0] rsp_left_x,
   output logic signed [15:0] rsp_left_y,
   output logic signed [15:0] rsp_left_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   output logic signed [15:0] rsp_forward_x,
   output logic signed [15:0] rsp_forward_y,
   output logic signed [15:0] rsp_forward_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);
   import vab_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL_H = 4'd1;
   localparam logic [3:0] ST_ADD_H = 4'd2;
   localparam logic [3:0] ST_WRAP  = 4'd3;
   localparam logic [3:0] ST_MUL_V = 4'd4;
   localparam logic [3:0] ST_ADD_V = 4'd5;
   localparam logic [3:0] ST_RECIP = 4'd6;
   localparam logic [3:0] ST_START = 4'd7;
   localparam logic [3:0] ST_CORD  = 4'd8;
   localparam logic [3:0] ST_PMUL  = 4'd9;
   localparam logic [3:0] ST_PRND  = 4'd10;
   localparam logic [3:0] ST_SEND  = 4'd11;

   localparam int SH30 = 30 - OUT_FRAC_BITS;
   localparam int SH60 = 60 - OUT_FRAC_BITS;
   localparam logic signed [63:0] HALF30 = 64'sd1 <<< (SH30 - 1);
   localparam logic signed [63:0] HALF60 = 64'sd1 <<< (SH60 - 1);
   localparam logic signed [63:0] LIM    = 64'sd1 <<< OUT_FRAC_BITS;
   localparam logic signed [63:0] SAT_HI = (LIM > 64'sd32767) ? 64'sd32767 : LIM;
   localparam logic signed [63:0] SAT_LO = (LIM > 64'sd32768) ? -64'sd32768 : -LIM;
   localparam logic signed [17:0] TURN18 = 18'sd23040;

   // round half up, then saturate to the output range
   function automatic logic [15:0] round_out(input logic signed [63:0] v,
                                             input logic wide_frac);
      logic signed [63:0] sum;
      logic signed [63:0] r;
      sum = v + (wide_frac ? HALF60 : HALF30);
      r   = wide_frac ? (sum >>> SH60) : (sum >>> SH30);
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[15:0];
   endfunction

   logic [3:0] state_ff, state_in;
   logic [14:0] dead_zone_ff, turn_gain_ff;
   logic [12:0] pitch_limit_ff;
   logic [14:0] yaw_ff, yaw_in;
   logic signed [13:0] pitch_ff, pitch_in;
   logic signed [15:0] h_ff, v_ff;
   logic h_act_ff, v_act_ff;
   logic signed [17:0] wrap_ff, wrap_in;
   logic sel_pitch_ff, sel_pitch_in;
   logic neg_ff, neg_in;
   logic [1:0] k_ff, k_in;
   trig_type sx_ff, cx_ff, sy_ff, cy_ff;
   logic signed [15:0] pv_ff [4];
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;
   logic rsp_valid_ff, rsp_valid_in;
   logic [14:0] o_yaw_ff;
   logic signed [13:0] o_pitch_ff;
   logic signed [15:0] o_left_x_ff, o_left_y_ff, o_left_z_ff;
   logic signed [15:0] o_up_y_ff, o_up_z_ff;
   logic signed [15:0] o_fwd_x_ff, o_fwd_y_ff, o_fwd_z_ff;

   logic req_xfer, load_out;
   logic [16:0] h_abs, v_abs;
   logic signed [63:0] rnd;
   logic signed [17:0] delta, pitch_sum, lim18;
   logic [14:0] ang_r, a45;
   logic [8:0] quo;
   logic [14:0] rem_full;
   logic [31:0] bam;
   logic fold;
   logic cord_start, cord_done;
   cordic_res_type cord_res;
   trig_type s_fix, c_fix;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign load_out  = (state_ff == ST_SEND) && !(rsp_valid_ff && rsp_stall);

   // dead zone test on the raw axes
   assign h_abs = req_horizontal_axis[15] ? 17'(-18'(req_horizontal_axis))
                                          : 17'(req_horizontal_axis);
   assign v_abs = req_vertical_axis[15] ? 17'(-18'(req_vertical_axis))
                                        : 17'(req_vertical_axis);

   // angle step: round(axis * gain / 2^15)
   assign rnd       = prod_ff + 64'sd16384;
   assign delta     = rnd[32:15];
   assign lim18     = 18'(signed'({1'b0, pitch_limit_ff}));
   assign pitch_sum = 18'(pitch_ff) + delta;

   // angle to binary angle: r = 45*a + b, bam = a*2^23 + frac(b)
   assign ang_r = sel_pitch_ff ? (pitch_ff[13] ? 15'(16'(pitch_ff) + 16'(FULL_TURN))
                                               : 15'(pitch_ff))
                               : ((yaw_ff == 15'(FULL_TURN)) ? 15'd0 : yaw_ff);
   assign quo      = prod_ff[28:20];
   assign a45      = (15'(quo) << 5) + (15'(quo) << 3) + (15'(quo) << 2) + 15'(quo);
   assign rem_full = ang_r - a45;
   assign bam      = {quo, FRAC_TAB[rem_full[5:0]]};
   assign fold     = bam[31] ^ bam[30];
   assign cord_start = (state_ff == ST_START);

   assign s_fix = neg_ff ? -cord_res.sin_val : cord_res.sin_val;
   assign c_fix = neg_ff ? -cord_res.cos_val : cord_res.cos_val;

   vab_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .angle (signed'({~fold ^ ~bam[31], bam[30:0]})),
      .done  (cord_done),
      .result(cord_res)
   );

   // shared multiplier operand selection
   always_comb begin
      mul_a = 32'(h_ff);
      mul_b = 32'(signed'({1'b0, turn_gain_ff}));
      unique case (state_ff)
         ST_MUL_V: mul_a = 32'(v_ff);
         ST_RECIP: begin
            mul_a = 32'(signed'({1'b0, ang_r}));
            mul_b = 32'(signed'({1'b0, RECIP45}));
         end
         ST_PMUL: begin
            unique case (k_ff)
               2'd0: begin mul_a = sx_ff;  mul_b = sy_ff; end
               2'd1: begin mul_a = -cx_ff; mul_b = sy_ff; end
               2'd2: begin mul_a = -sx_ff; mul_b = cy_ff; end
               default: begin mul_a = cx_ff; mul_b = cy_ff; end
            endcase
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      wrap_in      = wrap_ff;
      sel_pitch_in = sel_pitch_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_MUL_H;
         ST_MUL_H: state_in = ST_ADD_H;
         ST_ADD_H: begin
            if (h_act_ff) begin
               wrap_in  = 18'(signed'({1'b0, yaw_ff})) + delta;
               state_in = ST_WRAP;
            end else begin
               state_in = ST_MUL_V;
            end
         end
         ST_WRAP: begin
            priority if (wrap_ff > TURN18) wrap_in = wrap_ff - TURN18;
            else if (wrap_ff[17]) wrap_in = wrap_ff + TURN18;
            else begin
               yaw_in   = wrap_ff[14:0];
               state_in = ST_MUL_V;
            end
         end
         ST_MUL_V: state_in = ST_ADD_V;
         ST_ADD_V: begin
            if (v_act_ff) begin
               priority if (pitch_sum > lim18) pitch_in = lim18[13:0];
               else if (pitch_sum < -lim18) pitch_in = 14'(-lim18);
               else pitch_in = pitch_sum[13:0];
            end
            sel_pitch_in = 1'b0;
            state_in     = ST_RECIP;
         end
         ST_RECIP: state_in = ST_START;
         ST_START: begin
            neg_in   = fold;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cord_done) begin
               if (!sel_pitch_ff) begin
                  sel_pitch_in = 1'b1;
                  state_in     = ST_RECIP;
               end else begin
                  k_in     = 2'd0;
                  state_in = ST_PMUL;
               end
            end
         end
         ST_PMUL: state_in = ST_PRND;
         ST_PRND: begin
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? ST_SEND : ST_PMUL;
         end
         ST_SEND: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and angle state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         yaw_ff         <= '0;
         pitch_ff       <= '0;
         sel_pitch_ff   <= 1'b0;
         neg_ff         <= 1'b0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         dead_zone_ff   <= DEAD_ZONE_RST;
         turn_gain_ff   <= TURN_GAIN_RST;
         pitch_limit_ff <= PITCH_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         sel_pitch_ff <= sel_pitch_in;
         neg_ff       <= neg_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_DEAD_ZONE:   dead_zone_ff   <= csr_data;
               REG_TURN_GAIN:   turn_gain_ff   <= csr_data;
               REG_PITCH_LIMIT: pitch_limit_ff <= csr_data[12:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      wrap_ff <= wrap_in;
      if (req_xfer) begin
         h_ff     <= req_horizontal_axis;
         v_ff     <= req_vertical_axis;
         h_act_ff <= h_abs > 17'(dead_zone_ff);
         v_act_ff <= v_abs > 17'(dead_zone_ff);
      end
      if (state_ff == ST_CORD && cord_done) begin
         if (!sel_pitch_ff) begin
            sx_ff <= s_fix;
            cx_ff <= c_fix;
         end else begin
            sy_ff <= s_fix;
            cy_ff <= c_fix;
         end
      end
      if (state_ff == ST_PRND) pv_ff[k_ff] <= round_out(prod_ff, 1'b1);
      if (load_out) begin
         o_yaw_ff    <= yaw_ff;
         o_pitch_ff  <= pitch_ff;
         o_left_x_ff <= round_out(64'(cy_ff), 1'b0);
         o_left_y_ff <= pv_ff[0];
         o_left_z_ff <= pv_ff[1];
         o_up_y_ff   <= round_out(64'(cx_ff), 1'b0);
         o_up_z_ff   <= round_out(64'(sx_ff), 1'b0);
         o_fwd_x_ff  <= round_out(64'(sy_ff), 1'b0);
         o_fwd_y_ff  <= pv_ff[2];
         o_fwd_z_ff  <= pv_ff[3];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yaw_now   = o_yaw_ff;
   assign rsp_pitch_now = o_pitch_ff;
   assign rsp_left_x    = o_left_x_ff;
   assign rsp_left_y    = o_left_y_ff;
   assign rsp_left_z    = o_left_z_ff;
   assign rsp_up_x      = '0;
   assign rsp_up_y      = o_up_y_ff;
   assign rsp_up_z      = o_up_z_ff;
   assign rsp_forward_x = o_fwd_x_ff;
   assign rsp_forward_y = o_fwd_y_ff;
   assign rsp_forward_z = o_fwd_z_ff;

endmodule

// ===== rtl/vab_cordic.sv =====
// iterative rotation-mode cordic giving sine and cosine of a binary angle
module vab_cordic #(
   parameter int CORDIC_STEPS = vab_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [31:0]       angle,
   output logic                     done,
   output vab_pkg::cordic_res_type  result
);
   import vab_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : CORDIC_STEPS;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [CW-1:0] x_sh, y_sh, atan_v;

   // one micro-rotation per cycle
   always_comb begin
      x_sh   = x_ff >>> i_ff;
      y_sh   = y_ff >>> i_ff;
      atan_v = CW'(signed'({1'b0, ATAN_TAB[i_ff]}));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = CW'(angle);
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done           = done_ff;
   assign result.sin_val = y_ff[31:0];
   assign result.cos_val = x_ff[31:0];

endmodule

// ===== tb/vab_checker.sv =====
// checker: watches both channels, predicts view angles and basis, compares
module vab_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_horizontal_axis,
   input  logic signed [15:0] req_vertical_axis,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [14:0]        rsp_yaw_now,
   input  logic signed [13:0] rsp_pitch_now,
   input  logic signed [15:0] rsp_left_x,
   input  logic signed [15:0] rsp_left_y,
   input  logic signed [15:0] rsp_left_z,
   input  logic signed [15:0] rsp_up_x,
   input  logic signed [15:0] rsp_up_y,
   input  logic signed [15:0] rsp_up_z,
   input  logic signed [15:0] rsp_forward_x,
   input  logic signed [15:0] rsp_forward_y,
   input  logic signed [15:0] rsp_forward_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count
);
   import vab_pkg::*;

   localparam int STEPS = 16;
   localparam int FRAC  = 14;

   typedef struct {
      logic [14:0]        yaw;
      logic signed [13:0] pitch;
      logic signed [15:0] vec [9];
   } view_type;

   view_type basis_q[$];

   longint atan_vals [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81};

   logic [14:0] dz_reg, gain_reg;
   logic [12:0] plim_reg;
   int yaw_st, pitch_st;

   assign pending_count = basis_q.size();

   // floor division by a power of two
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void trig(int a, output longint s, output longint c);
      int r;
      longint unsigned bam;
      longint z, x, y, t;
      bit neg;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      bam = ((longint'(r) << 32) + FULL_TURN / 2) / FULL_TURN;
      bam = bam & 64'hFFFF_FFFF;
      neg = 0;
      if (bam >= 64'h4000_0000 && bam < 64'hC000_0000) begin
         bam = (bam + 64'h8000_0000) & 64'hFFFF_FFFF;
         neg = 1;
      end
      z = (bam >= 64'h8000_0000) ? longint'(bam) - 64'sh1_0000_0000 : longint'(bam);
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         if (z >= 0) begin
            t = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z -= atan_vals[i];
         end else begin
            t = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z += atan_vals[i];
         end
         x = t;
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
   endfunction

   // round half up, saturate to unit range and 16 bits
   function automatic logic signed [15:0] quantize(longint v, int frac_in);
      int sh;
      longint lim, r;
      sh = frac_in - FRAC;
      lim = longint'(1) << FRAC;
      r = shr_floor(v + (longint'(1) << (sh - 1)), sh);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic int turn_step(longint axis);
      return int'(shr_floor(axis * longint'(gain_reg) + 16384, 15));
   endfunction

   function automatic view_type predict_view(longint h, longint v);
      view_type e;
      longint sx, cx, sy, cy;
      longint ah, av;
      ah = h < 0 ? -h : h;
      av = v < 0 ? -v : v;
      if (ah > longint'(dz_reg)) begin
         yaw_st += turn_step(h);
         while (yaw_st > FULL_TURN) yaw_st -= FULL_TURN;
         while (yaw_st < 0) yaw_st += FULL_TURN;
      end
      if (av > longint'(dz_reg)) begin
         pitch_st += turn_step(v);
         if (pitch_st > int'(plim_reg)) pitch_st = plim_reg;
         if (pitch_st < -int'(plim_reg)) pitch_st = -int'(plim_reg);
      end
      trig(yaw_st, sx, cx);
      trig(pitch_st, sy, cy);
      e.yaw = yaw_st[14:0];
      e.pitch = pitch_st[13:0];
      e.vec[0] = quantize(cy, 30);
      e.vec[1] = quantize(sx * sy, 60);
      e.vec[2] = quantize(-(cx * sy), 60);
      e.vec[3] = 0;
      e.vec[4] = quantize(cx, 30);
      e.vec[5] = quantize(sx, 30);
      e.vec[6] = quantize(sy, 30);
      e.vec[7] = quantize(-(sx * cy), 60);
      e.vec[8] = quantize(cx * cy, 60);
      return e;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   // track registers, predict on request transfer, compare on result transfer
   always @(posedge clock) begin
      view_type e;
      logic signed [15:0] got [9];
      if (reset) begin
         dz_reg <= DEAD_ZONE_RST;
         gain_reg <= TURN_GAIN_RST;
         plim_reg <= PITCH_LIMIT_RST;
         yaw_st = 0;
         pitch_st = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_DEAD_ZONE: begin
                  dz_reg <= csr_data;
               end
               REG_TURN_GAIN: begin
                  gain_reg <= csr_data;
               end
               REG_PITCH_LIMIT: begin
                  plim_reg <= csr_data[12:0];
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            basis_q.push_back(predict_view(req_horizontal_axis, req_vertical_axis));
         if (rsp_valid && !rsp_stall) begin
            if (basis_q.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               e = basis_q.pop_front();
               got = '{rsp_left_x, rsp_left_y, rsp_left_z, rsp_up_x, rsp_up_y,
                       rsp_up_z, rsp_forward_x, rsp_forward_y, rsp_forward_z};
               if (rsp_yaw_now !== e.yaw) report_mismatch("yaw_now", rsp_yaw_now, e.yaw);
               if (rsp_pitch_now !== e.pitch)
                  report_mismatch("pitch_now", rsp_pitch_now, e.pitch);
               for (int i = 0; i < 9; i++)
                  if (got[i] !== e.vec[i]) report_mismatch($sformatf("basis term %0d", i),
                                                           got[i], e.vec[i]);
            end
         end
      end
   end
endmodule

// ===== tb/tb_view_angle_to_basis_top.sv =====
// testbench top: clock, reset, stick ticks, register writes and verdict
module tb_view_angle_to_basis_top;
   import vab_pkg::*;

   localparam int LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [15:0] req_horizontal_axis, req_vertical_axis;
   logic [14:0] rsp_yaw_now;
   logic signed [13:0] rsp_pitch_now;
   logic signed [15:0] lx, ly, lz, ux, uy, uz, fx, fy, fz;
   logic csr_write;
   logic [1:0] csr_index;
   logic [14:0] csr_data;
   int fail_count, pending_count;
   int idle_cycles;
   int send_idle_pct, recv_stall_pct;

   view_angle_to_basis_top u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_horizontal_axis,
      .req_vertical_axis, .rsp_valid, .rsp_stall, .rsp_yaw_now, .rsp_pitch_now,
      .rsp_left_x(lx), .rsp_left_y(ly), .rsp_left_z(lz), .rsp_up_x(ux),
      .rsp_up_y(uy), .rsp_up_z(uz), .rsp_forward_x(fx), .rsp_forward_y(fy),
      .rsp_forward_z(fz), .csr_write, .csr_index, .csr_data);

   vab_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_horizontal_axis,
      .req_vertical_axis, .rsp_valid, .rsp_stall, .rsp_yaw_now, .rsp_pitch_now,
      .rsp_left_x(lx), .rsp_left_y(ly), .rsp_left_z(lz), .rsp_up_x(ux),
      .rsp_up_y(uy), .rsp_up_z(uz), .rsp_forward_x(fx), .rsp_forward_y(fy),
      .rsp_forward_z(fz), .csr_write, .csr_index, .csr_data,
      .fail_count, .pending_count);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver stall, changed at falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("tb_view_angle_to_basis_top NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [14:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
   endtask

   // one tick transfer, with random sender idling before it; valid stays up
   // after the transfer until the next tick or an idle cycle replaces it
   task automatic send_tick(logic signed [15:0] h, logic signed [15:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_horizontal_axis <= h;
      req_vertical_axis <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(6000));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [15:0] ax [6];
      ax = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd5243, 16'sd5244, -16'sd5244};
      req_valid = 0;
      req_horizontal_axis = 0;
      req_vertical_axis = 0;
      csr_write = 0;
      csr_index = REG_DEAD_ZONE;
      csr_data = 0;
      rsp_stall = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      idle_cycles = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: axis extremes and dead zone edges at reset settings
      foreach (ax[i]) send_tick(ax[i], ax[5 - i]);
      repeat (6) send_tick(16'sh7fff, 16'sh7fff);
      drain();
      // large gain and large limit
      write_reg(REG_TURN_GAIN, 15'h7fff);
      write_reg(REG_PITCH_LIMIT, 15'h1fff);
      write_reg(REG_DEAD_ZONE, 15'd0);
      repeat (4) send_tick(16'sh8000, 16'sh7fff);
      send_tick(16'sd1, -16'sd1);
      drain();
      // lowered limit applies only with active vertical axis
      write_reg(REG_PITCH_LIMIT, 15'd0);
      write_reg(REG_DEAD_ZONE, 15'h7fff);
      send_tick(16'sh7fff, 16'sh8000);
      send_tick(16'sh7fff, 16'sh7fff);
      drain();

      // random phases with varied settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         write_reg(REG_DEAD_ZONE, (ph == 7) ? 15'h7fff : 15'($urandom_range(ph * 800)));
         write_reg(REG_TURN_GAIN, (ph == 6) ? 15'h7fff : 15'($urandom_range(23040)));
         write_reg(REG_PITCH_LIMIT, (ph == 5) ? 15'h1fff : 15'($urandom_range(5760)));
         repeat (88) send_tick(rand_axis(), rand_axis());
         drain();
      end

      if (fail_count == 0)
         $display("tb_view_angle_to_basis_top OK");
      else
         $display("tb_view_angle_to_basis_top NOT OK");
      $finish;
   end
endmodule
